/* hw/rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and types of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ARENA_BYTES     = 65536;
  localparam int MIN_BLOCK_BYTES = 32;
  localparam int ORDER_COUNT     = 11;

  localparam int ADDR_W    = 16;
  localparam int HDR_W     = 5;
  localparam int UNIT_COUNT = ARENA_BYTES / MIN_BLOCK_BYTES;
  localparam int UNIT_W    = $clog2(UNIT_COUNT);
  localparam int MIN_SHIFT = $clog2(MIN_BLOCK_BYTES);
  localparam int ORDER_W   = $clog2(ORDER_COUNT);

  // free bitmap rows: each order starts on a row of its own
  localparam int ROW_BITS  = 32;
  localparam int ROW_SHIFT = 5;

  function automatic int order_rows(input int k);
    int n;
    n = UNIT_COUNT >> k;
    return (n + ROW_BITS - 1) >> ROW_SHIFT;
  endfunction

  function automatic int row_base(input int k);
    int acc;
    acc = 0;
    for (int j = 0; j < k; j++) acc += order_rows(j);
    return acc;
  endfunction

  localparam int FREE_ROWS  = row_base(ORDER_COUNT);
  localparam int FROW_W     = $clog2(FREE_ROWS);
  localparam int TOP_ROW    = row_base(ORDER_COUNT - 1);
  localparam int TOP_BLOCKS = UNIT_COUNT >> (ORDER_COUNT - 1);
  localparam logic [ROW_BITS-1:0] TOP_MASK = ROW_BITS'((64'd1 << TOP_BLOCKS) - 64'd1);
  localparam logic [FREE_ROWS-1:0] NONEMPTY_RESET = FREE_ROWS'(1) << TOP_ROW;

  // block table: {mark, order} per unit, packed eight units to a row
  localparam int ENT_W      = ORDER_W + 1;
  localparam int MARK_PER_ROW = 8;
  localparam int MSEL_W     = $clog2(MARK_PER_ROW);
  localparam int MARK_ROWS  = UNIT_COUNT / MARK_PER_ROW;
  localparam int MROW_W     = $clog2(MARK_ROWS);

  // row scan width of the summary flags
  localparam int SCAN_N = 8;
  localparam int SCAN_W = $clog2(SCAN_N);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  localparam logic REG_HEADER    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef logic [3:0] cmd_t;
  localparam cmd_t C_NOP      = 4'd0;
  localparam cmd_t C_LOAD     = 4'd1;
  localparam cmd_t C_DECODE   = 4'd2;
  localparam cmd_t C_SCAN     = 4'd3;
  localparam cmd_t C_TAKE     = 4'd4;
  localparam cmd_t C_SPLIT_RD = 4'd5;
  localparam cmd_t C_BIT_SET  = 4'd6;
  localparam cmd_t C_MARK_RD  = 4'd7;
  localparam cmd_t C_MARK_WR  = 4'd8;
  localparam cmd_t C_MRG_RD   = 4'd9;
  localparam cmd_t C_MRG_CHK  = 4'd10;
  localparam cmd_t C_SET_RD   = 4'd11;
  localparam cmd_t C_RESULT   = 4'd12;

  typedef struct packed {
    logic is_free;
    logic reject;
    logic addr_bad;
    logic scan_hit;
    logic above_need;
    logic marked;
    logic can_merge;
    logic buddy_free;
    logic out_busy;
  } dp_stat_t;

endpackage

/* hw/rtl/bba_in_if.sv */
// ----------------------------------------------------------------------------
// bba_in_if
// Request channel: allocate or free word.
// ----------------------------------------------------------------------------
interface bba_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] request_bytes;
  logic [15:0] address;
  modport source (output valid, op, request_bytes, address, input ready);
  modport sink   (input valid, op, request_bytes, address, output ready);
endinterface

/* hw/rtl/bba_out_if.sv */
// ----------------------------------------------------------------------------
// bba_out_if
// Result channel: offset and status word.
// ----------------------------------------------------------------------------
interface bba_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_offset;
  logic [1:0]  status;
  modport source (output valid, result_offset, status, input ready);
  modport sink   (input valid, result_offset, status, output ready);
endinterface

/* hw/rtl/bba_cfg_if.sv */
// ----------------------------------------------------------------------------
// bba_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface bba_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/buddy_block_allocator_unit.sv */
// Flow: one word in flight; the next is taken the cycle after its result is loaded;
//   a full result register stalls the walk.
// Reset: synchronous, active low; bitmap and block-table rows fall back to their
//   reset contents through row valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Buddy allocator over a 64 KiB arena, blocks of 32 B to 32 KiB.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit (
  input  logic clk,
  input  logic rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink   cfg_ch
);

  bba_pkg::cmd_t     cmd;
  bba_pkg::dp_stat_t st;
  logic              in_ready;

  // register writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // sequencer: one state per memory access of the search/split/merge walk
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_ch.valid && in_ready),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // datapath: bitmap rows, block table, result word register
  bba_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_op             (in_ch.op),
    .in_request_bytes  (in_ch.request_bytes),
    .in_address        (in_ch.address),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_result_offset (out_ch.result_offset),
    .out_status        (out_ch.status)
  );

endmodule

/* hw/rtl/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: steps the datapath through search, split, merge and result.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  bba_pkg::dp_stat_t st,
  output logic              in_ready,
  output bba_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_TAKE     = 4'd3;
  localparam logic [3:0] S_SPLIT    = 4'd4;
  localparam logic [3:0] S_SPLIT_WR = 4'd5;
  localparam logic [3:0] S_MARK_WR  = 4'd6;
  localparam logic [3:0] S_MCHK     = 4'd7;
  localparam logic [3:0] S_MERGE    = 4'd8;
  localparam logic [3:0] S_MRG_CHK  = 4'd9;
  localparam logic [3:0] S_SET      = 4'd10;
  localparam logic [3:0] S_SET_WR   = 4'd11;
  localparam logic [3:0] S_RESULT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = bba_pkg::C_NOP;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd       = bba_pkg::C_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd = bba_pkg::C_DECODE;
        if (st.is_free) state_nxt = st.addr_bad ? S_RESULT : S_MCHK;
        else            state_nxt = st.reject ? S_RESULT : S_SCAN;
      end
      S_SCAN: begin
        cmd = bba_pkg::C_SCAN;
        if (st.scan_hit) state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd       = bba_pkg::C_TAKE;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (st.above_need) begin
          cmd       = bba_pkg::C_SPLIT_RD;
          state_nxt = S_SPLIT_WR;
        end else begin
          cmd       = bba_pkg::C_MARK_RD;
          state_nxt = S_MARK_WR;
        end
      end
      S_SPLIT_WR: begin
        cmd       = bba_pkg::C_BIT_SET;
        state_nxt = S_SPLIT;
      end
      S_MARK_WR: begin
        cmd       = bba_pkg::C_MARK_WR;
        state_nxt = S_RESULT;
      end
      S_MCHK: begin
        if (st.marked) begin
          cmd       = bba_pkg::C_MARK_WR;
          state_nxt = S_MERGE;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_MERGE: begin
        if (st.can_merge) begin
          cmd       = bba_pkg::C_MRG_RD;
          state_nxt = S_MRG_CHK;
        end else begin
          cmd       = bba_pkg::C_SET_RD;
          state_nxt = S_SET_WR;
        end
      end
      S_MRG_CHK: begin
        cmd       = bba_pkg::C_MRG_CHK;
        state_nxt = st.buddy_free ? S_MERGE : S_SET;
      end
      S_SET: begin
        cmd       = bba_pkg::C_SET_RD;
        state_nxt = S_SET_WR;
      end
      S_SET_WR: begin
        cmd       = bba_pkg::C_BIT_SET;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!st.out_busy) begin
          cmd       = bba_pkg::C_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/bba_datapath.sv */
// ----------------------------------------------------------------------------
// bba_datapath
// Free bitmap rows, block table, config registers and result register.
// ----------------------------------------------------------------------------
module bba_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bba_pkg::cmd_t                 cmd,
  output bba_pkg::dp_stat_t             st,
  input  logic                          in_op,
  input  logic [bba_pkg::ADDR_W-1:0]    in_request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]    in_address,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bba_pkg::ADDR_W-1:0]    out_result_offset,
  output logic [1:0]                    out_status
);

  localparam int AW  = bba_pkg::ADDR_W;
  localparam int UW  = bba_pkg::UNIT_W;
  localparam int KW  = bba_pkg::ORDER_W;
  localparam int RW  = bba_pkg::FROW_W;
  localparam int NR  = bba_pkg::FREE_ROWS;
  localparam int RB  = bba_pkg::ROW_BITS;
  localparam int RS  = bba_pkg::ROW_SHIFT;
  localparam int NK  = bba_pkg::ORDER_COUNT;
  localparam int EW  = bba_pkg::ENT_W;
  localparam int MPR = bba_pkg::MARK_PER_ROW;
  localparam int MW  = bba_pkg::MROW_W;
  localparam int MS  = bba_pkg::MSEL_W;
  localparam int SN  = bba_pkg::SCAN_N;

  // config
  logic [bba_pkg::HDR_W-1:0] hdr_r;
  logic [15:0]               thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= bba_pkg::HDR_W'(24);
      thr_r <= 16'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        bba_pkg::REG_HEADER:    hdr_r <= cfg_data[bba_pkg::HDR_W-1:0];
        bba_pkg::REG_THRESHOLD: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-order row layout
  logic [RW-1:0] rbase_c [NK];
  logic [RW:0]   rend_c  [NK];
  logic [NK-1:0] any_free;
  logic [NR-1:0] nonempty_r;

  for (genvar g = 0; g < NK; g++) begin : g_ord
    localparam int B = bba_pkg::row_base(g);
    localparam int N = bba_pkg::order_rows(g);
    localparam logic [NR-1:0] M = ({NR{1'b1}} >> (NR - N)) << B;
    assign rbase_c[g]  = RW'(B);
    assign rend_c[g]   = (RW + 1)'(B + N);
    assign any_free[g] = |(nonempty_r & M);
  end

  // item registers
  logic          op_r;
  logic [AW-1:0] req_r, addr_r;
  logic [KW-1:0] k_r, need_r;
  logic [UW-1:0] idx_r, unit_r;
  logic [RW-1:0] rp_r, row_r;
  logic [RS-1:0] bit_r;
  logic [AW-1:0] res_off_r;
  logic [1:0]    res_st_r;

  // allocate decode
  logic [AW:0]   total;
  logic          too_big, need_ok, found_ok;
  logic [KW-1:0] need, found_k;

  assign total   = {1'b0, req_r} + (AW + 1)'(hdr_r);
  assign too_big = total > {1'b0, thr_r};

  always_comb begin
    need    = '0;
    need_ok = 1'b0;
    for (int k = NK - 1; k >= 0; k--) begin
      if ((32'(bba_pkg::MIN_BLOCK_BYTES) << k) >= 32'(total)) begin
        need    = KW'(k);
        need_ok = 1'b1;
      end
    end
  end

  always_comb begin
    found_k  = '0;
    found_ok = 1'b0;
    for (int k = NK - 1; k >= 0; k--) begin
      if (KW'(k) >= need && any_free[k]) begin
        found_k  = KW'(k);
        found_ok = 1'b1;
      end
    end
  end

  // free decode
  logic [AW-1:0] off;
  logic          addr_bad;
  logic [UW-1:0] dec_unit;

  assign off      = addr_r - AW'(hdr_r);
  assign dec_unit = UW'(off >> bba_pkg::MIN_SHIFT);
  assign addr_bad = (addr_r < AW'(hdr_r)) || (off[bba_pkg::MIN_SHIFT-1:0] != '0) ||
                    (({1'b0, off} >> bba_pkg::MIN_SHIFT) >= (AW + 1)'(bba_pkg::UNIT_COUNT));

  // summary flag scan, several rows a cycle
  logic [SN-1:0]   scan_flag;
  logic            scan_hit;
  logic [RW-1:0]   scan_row;

  always_comb begin
    logic [RW:0] r;
    scan_hit = 1'b0;
    scan_row = rp_r;
    for (int j = 0; j < SN; j++) begin
      r = {1'b0, rp_r} + (RW + 1)'(j);
      scan_flag[j] = (r < rend_c[k_r]) && nonempty_r[r[RW-1:0]];
    end
    for (int j = SN - 1; j >= 0; j--) begin
      if (scan_flag[j]) begin
        scan_hit = 1'b1;
        scan_row = rp_r + RW'(j);
      end
    end
  end

  // free bitmap memory with per-row valid bits
  logic [RB-1:0] fmem [NR];
  logic [RB-1:0] fq_r;
  logic [NR-1:0] fvalid_r;
  logic [RB-1:0] frow;
  logic          frd_en, fwr_en;
  logic [RW-1:0] frd_row;
  logic [RS-1:0] frd_bit;
  logic [RB-1:0] fwr_data;
  logic [KW-1:0] tk;
  logic [UW-1:0] tidx;

  assign frow = fvalid_r[row_r] ? fq_r :
                ((row_r == RW'(bba_pkg::TOP_ROW)) ? bba_pkg::TOP_MASK : '0);

  // read target: order and block index
  always_comb begin
    tk   = k_r;
    tidx = idx_r;
    case (cmd)
      bba_pkg::C_SPLIT_RD: begin
        tk   = k_r - KW'(1);
        tidx = (idx_r << 1) | UW'(1);
      end
      bba_pkg::C_MRG_RD: tidx = idx_r ^ UW'(1);
      default: ;
    endcase
  end

  assign frd_row = (cmd == bba_pkg::C_SCAN) ? scan_row : rbase_c[tk] + RW'(tidx >> RS);
  assign frd_bit = tidx[RS-1:0];
  assign frd_en  = (cmd == bba_pkg::C_SCAN && scan_hit) || cmd == bba_pkg::C_SPLIT_RD ||
                   cmd == bba_pkg::C_MRG_RD || cmd == bba_pkg::C_SET_RD;

  logic [RS-1:0] first_bit;
  always_comb begin
    first_bit = '0;
    for (int b = RB - 1; b >= 0; b--) begin
      if (frow[b]) first_bit = RS'(b);
    end
  end

  logic buddy_free;
  assign buddy_free = frow[bit_r];

  always_comb begin
    fwr_en   = 1'b0;
    fwr_data = frow;
    case (cmd)
      bba_pkg::C_TAKE: begin
        fwr_en   = 1'b1;
        fwr_data = frow & ~(RB'(1) << first_bit);
      end
      bba_pkg::C_BIT_SET: begin
        fwr_en   = 1'b1;
        fwr_data = frow | (RB'(1) << bit_r);
      end
      bba_pkg::C_MRG_CHK: begin
        fwr_en   = buddy_free;
        fwr_data = frow & ~(RB'(1) << bit_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fwr_en) fmem[row_r] <= fwr_data;
    if (frd_en) fq_r <= fmem[frd_row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r   <= '0;
      nonempty_r <= bba_pkg::NONEMPTY_RESET;
    end else if (fwr_en) begin
      fvalid_r[row_r]   <= 1'b1;
      nonempty_r[row_r] <= |fwr_data;
    end
  end

  // block table: {mark, order} per unit, row valid bits
  logic [MPR*EW-1:0] mmem [bba_pkg::MARK_ROWS];
  logic [MPR*EW-1:0] mq_r;
  logic [bba_pkg::MARK_ROWS-1:0] mvalid_r;
  logic [MPR*EW-1:0] mrow, mwr_data;
  logic [EW-1:0]     ment;
  logic [UW-1:0]     mrd_unit;
  logic              mrd_en, mwr_en;
  logic [KW-1:0]     free_k;

  assign mrd_unit = (op_r == bba_pkg::OP_FREE) ? dec_unit : UW'(idx_r << k_r);
  assign mrd_en   = cmd == bba_pkg::C_MARK_RD ||
                    (cmd == bba_pkg::C_DECODE && op_r == bba_pkg::OP_FREE);
  assign mwr_en   = cmd == bba_pkg::C_MARK_WR;
  assign mrow     = mvalid_r[unit_r[UW-1:MS]] ? mq_r : '0;
  assign ment     = mrow[unit_r[MS-1:0]*EW +: EW];
  assign free_k   = (ment[KW-1:0] >= KW'(NK)) ? KW'(NK - 1) : ment[KW-1:0];

  always_comb begin
    mwr_data = mrow;
    if (op_r == bba_pkg::OP_FREE) mwr_data[unit_r[MS-1:0]*EW +: EW] = {1'b0, ment[KW-1:0]};
    else                          mwr_data[unit_r[MS-1:0]*EW +: EW] = {1'b1, k_r};
  end

  always_ff @(posedge clk) begin
    if (mwr_en) mmem[unit_r[UW-1:MS]] <= mwr_data;
    if (mrd_en) mq_r <= mmem[mrd_unit[UW-1:MS]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      mvalid_r <= '0;
    else if (mwr_en) mvalid_r[unit_r[UW-1:MS]] <= 1'b1;
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    case (cmd)
      bba_pkg::C_LOAD: begin
        op_r   <= in_op;
        req_r  <= in_request_bytes;
        addr_r <= in_address;
      end
      bba_pkg::C_DECODE: begin
        res_off_r <= '0;
        k_r       <= found_k;
        need_r    <= need;
        rp_r      <= rbase_c[found_k];
        if (op_r == bba_pkg::OP_FREE) begin
          res_st_r <= bba_pkg::ST_OK;
          unit_r   <= mrd_unit;
        end else if (too_big) begin
          res_st_r <= bba_pkg::ST_TOO_LARGE;
        end else if (!need_ok || !found_ok) begin
          res_st_r <= bba_pkg::ST_NO_SPACE;
        end else begin
          res_st_r <= bba_pkg::ST_OK;
        end
      end
      bba_pkg::C_SCAN: begin
        if (scan_hit) row_r <= scan_row;
        else          rp_r  <= rp_r + RW'(SN);
      end
      bba_pkg::C_TAKE:
        idx_r <= UW'({row_r - rbase_c[k_r], first_bit});
      bba_pkg::C_SPLIT_RD, bba_pkg::C_MRG_RD, bba_pkg::C_SET_RD: begin
        k_r   <= tk;
        row_r <= frd_row;
        bit_r <= frd_bit;
        if (cmd == bba_pkg::C_SPLIT_RD) idx_r <= idx_r << 1;
      end
      bba_pkg::C_MARK_RD: unit_r <= mrd_unit;
      bba_pkg::C_MARK_WR: begin
        if (op_r == bba_pkg::OP_FREE) begin
          k_r   <= free_k;
          idx_r <= unit_r >> free_k;
        end else begin
          res_off_r <= AW'({unit_r, {bba_pkg::MIN_SHIFT{1'b0}}}) + AW'(hdr_r);
        end
      end
      bba_pkg::C_MRG_CHK: begin
        if (buddy_free) begin
          idx_r <= idx_r >> 1;
          k_r   <= k_r + KW'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  logic          out_valid_r;
  logic [AW-1:0] out_off_r;
  logic [1:0]    out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == bba_pkg::C_RESULT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == bba_pkg::C_RESULT) begin
      out_off_r <= res_off_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_offset = out_off_r;
  assign out_status        = out_st_r;

  // status to the sequencer
  assign st.is_free    = op_r;
  assign st.reject     = too_big || !need_ok || !found_ok;
  assign st.addr_bad   = addr_bad;
  assign st.scan_hit   = scan_hit;
  assign st.above_need = k_r > need_r;
  assign st.marked     = ment[EW-1];
  assign st.can_merge  = ({1'b0, k_r} + (KW + 1)'(1)) < (KW + 1)'(NK);
  assign st.buddy_free = buddy_free;
  assign st.out_busy   = out_valid_r && !out_ready;

endmodule
